// ===== rtl/pff_pkg.sv =====
// ----------------------------------------------------------------------------
// pff_pkg: shared types and codes for the priority flood fill block
// Commands, status codes, register indexes and the controller/datapath link.
// ----------------------------------------------------------------------------
package pff_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NOFILL = 2'd2;

    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic REG_GRID_DEPTH = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_SEED_GEN,
        S_VISIT,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_CHK,
        S_POP_TOP,
        S_POP_LAST,
        S_SIFT_L,
        S_SIFT_R,
        S_SIFT_CMP,
        S_PCELL,
        S_PDIST,
        S_PDIST_CAP,
        S_NBR_GEN,
        S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ_ISSUE,
        OP_READ_OUT,
        OP_REJECT,
        OP_RUN_BAD,
        OP_RUN_INIT,
        OP_CLEAR,
        OP_SEED_GEN,
        OP_VISIT_SEED,
        OP_VISIT_FLOOD,
        OP_PUSH_RD,
        OP_PUSH_CMP,
        OP_POP_RD0,
        OP_POP_TOP,
        OP_POP_LAST,
        OP_SIFT_L,
        OP_SIFT_R,
        OP_SIFT_CMP,
        OP_PCELL,
        OP_PDIST,
        OP_PDIST_CAP,
        OP_NBR_GEN,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctl_t;

    typedef struct packed {
        logic grid_ok;
        logic clear_last;
        logic gen_done;
        logic fresh;
        logic push_top;
        logic push_up;
        logic heap_empty;
        logic sift_leaf;
        logic sift_down;
        logic nbr_valid;
        logic nbr_last;
    } dp_status_t;

endpackage

// ===== rtl/pff_ctrl.sv =====
// ----------------------------------------------------------------------------
// pff_ctrl: sequencer for the priority flood fill
// Decodes commands and steps the datapath through clear, seed, heap and
// neighbor phases.
// ----------------------------------------------------------------------------
module pff_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          cmd,
    input  pff_pkg::dp_status_t st,
    output pff_pkg::dp_ctl_t    ctl,
    output logic                busy
);
    import pff_pkg::*;

    state_t state_reg, state_next;
    logic   flood_reg, flood_next;
    state_t after_gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            flood_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flood_reg <= flood_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        flood_next = flood_reg;
        ctl.op     = OP_NONE;
        if (st.gen_done)
            after_gen = S_POP_CHK;
        else if (flood_reg)
            after_gen = S_NBR_GEN;
        else
            after_gen = S_SEED_GEN;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_WRITE: ctl.op = OP_WRITE;
                        CMD_READ:
                        begin
                            ctl.op     = OP_READ_ISSUE;
                            state_next = S_READ;
                        end
                        CMD_RUN:
                        begin
                            if (st.grid_ok)
                            begin
                                ctl.op     = OP_RUN_INIT;
                                state_next = S_CLEAR;
                                flood_next = 1'b0;
                            end
                            else
                                ctl.op = OP_RUN_BAD;
                        end
                        default: ctl.op = OP_REJECT;
                    endcase
                end
            end
            S_READ:
            begin
                ctl.op     = OP_READ_OUT;
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                ctl.op = OP_CLEAR;
                if (st.clear_last)
                    state_next = S_SEED_GEN;
            end
            S_SEED_GEN:
            begin
                ctl.op     = OP_SEED_GEN;
                state_next = S_VISIT;
            end
            S_VISIT:
            begin
                ctl.op     = flood_reg ? OP_VISIT_FLOOD : OP_VISIT_SEED;
                state_next = st.fresh ? S_PUSH_RD : after_gen;
            end
            S_PUSH_RD:
            begin
                ctl.op     = OP_PUSH_RD;
                state_next = st.push_top ? after_gen : S_PUSH_CMP;
            end
            S_PUSH_CMP:
            begin
                ctl.op     = OP_PUSH_CMP;
                state_next = st.push_up ? S_PUSH_RD : after_gen;
            end
            S_POP_CHK:
            begin
                ctl.op     = OP_POP_RD0;
                flood_next = 1'b1;
                state_next = st.heap_empty ? S_FINISH : S_POP_TOP;
            end
            S_POP_TOP:
            begin
                ctl.op     = OP_POP_TOP;
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                ctl.op     = OP_POP_LAST;
                state_next = S_SIFT_L;
            end
            S_SIFT_L:
            begin
                ctl.op     = OP_SIFT_L;
                state_next = st.sift_leaf ? S_PCELL : S_SIFT_R;
            end
            S_SIFT_R:
            begin
                ctl.op     = OP_SIFT_R;
                state_next = S_SIFT_CMP;
            end
            S_SIFT_CMP:
            begin
                ctl.op     = OP_SIFT_CMP;
                state_next = st.sift_down ? S_SIFT_L : S_PCELL;
            end
            S_PCELL:
            begin
                ctl.op     = OP_PCELL;
                state_next = S_PDIST;
            end
            S_PDIST:
            begin
                ctl.op     = OP_PDIST;
                state_next = S_PDIST_CAP;
            end
            S_PDIST_CAP:
            begin
                ctl.op     = OP_PDIST_CAP;
                state_next = S_NBR_GEN;
            end
            S_NBR_GEN:
            begin
                ctl.op = OP_NBR_GEN;
                if (st.nbr_valid)
                    state_next = S_VISIT;
                else if (st.nbr_last)
                    state_next = S_POP_CHK;
            end
            S_FINISH:
            begin
                ctl.op     = OP_FINISH;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/pff_datapath.sv =====
// ----------------------------------------------------------------------------
// pff_datapath: grid stores, pending heap and result registers
// Executes one controller operation per cycle on memories with a write port, a
// separate read port and registered reads.
// ----------------------------------------------------------------------------
module pff_datapath #(
    parameter int MAX_CELLS   = 4096,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pff_pkg::dp_ctl_t    ctl,
    output pff_pkg::dp_status_t st,
    input  logic [11:0]         cell_index,
    input  logic [15:0]         height,
    input  logic                wr_en,
    input  logic                wr_index,
    input  logic [12:0]         wr_data,
    output logic                done,
    output logic [1:0]          status,
    output logic [15:0]         filled_height,
    output logic                has_downstream,
    output logic [11:0]         downstream_cell,
    output logic [11:0]         edge_distance
);
    import pff_pkg::*;

    localparam int CW = $clog2(MAX_CELLS);
    localparam int HB = HEIGHT_BITS;

    typedef struct packed {
        logic [HB-1:0] elev;
        logic [CW-1:0] seq;
        logic [CW-1:0] x;
        logic [CW-1:0] z;
    } entry_t;

    function automatic logic less(entry_t a, entry_t b);
        less = (a.elev < b.elev) || ((a.elev == b.elev) && (a.seq < b.seq));
    endfunction

    // memories
    logic [HB-1:0] height_mem  [MAX_CELLS];
    logic [HB-1:0] filled_mem  [MAX_CELLS];
    logic [CW:0]   drain_mem   [MAX_CELLS];
    logic [CW-1:0] dist_mem    [MAX_CELLS];
    logic          visited_mem [MAX_CELLS];
    entry_t        heap_mem    [MAX_CELLS];

    logic [HB-1:0] height_rd, filled_rd;
    logic [CW:0]   drain_rd;
    logic [CW-1:0] dist_rd;
    logic          visited_rd;
    entry_t        heap_rd;

    // registers
    logic [12:0]   w_reg, d_reg;
    logic [25:0]   area_reg;
    logic          ready_reg;
    logic [11:0]   idx_reg;
    logic [CW-1:0] gcnt_reg, row_base_reg, last_base_reg;
    logic          gphase_reg, gside_reg, gen_done_reg;
    logic [CW-1:0] cur_cell_reg, cur_x_reg, cur_z_reg;
    entry_t        e_reg, top_reg, last_reg, lch_reg;
    logic [CW-1:0] hi_reg, pidx_reg;
    logic [CW:0]   heap_cnt_reg;
    logic [CW-1:0] seq_reg;
    logic [CW+1:0] lidx_reg;
    logic          has_r_reg;
    logic [CW-1:0] pcell_reg, pdist_reg;
    logic [1:0]    dxi_reg, dzi_reg;
    logic          done_reg;
    logic [1:0]    status_reg;
    logic [15:0]   fh_reg;
    logic          hd_reg;
    logic [11:0]   dc_reg, ed_reg;

    // combinational
    logic          grid_ok, in_range_in, in_range_idx;
    logic [25:0]   area_next;
    logic [CW-1:0] wc, dc, mul_a;
    logic [CW+12:0] mul_prod;
    logic [CW-1:0] seed_cell, seed_x, seed_z;
    logic [CW:0]   nx1, nz1;
    logic          nbr_valid, nbr_last;
    logic [CW-1:0] nbr_base, nbr_cell;
    logic [CW-1:0] gen_addr, dist_raddr, heap_raddr;
    logic [CW+1:0] sift_l;
    logic          sift_leaf, sel_r, sift_down;
    entry_t        child;
    logic [CW+1:0] midx;
    logic [HB-1:0] flood_elev, visit_elev;
    logic          visit_we, visit_wd;
    logic [CW-1:0] visit_addr;
    logic          store_we;
    logic          heap_we;
    logic [CW-1:0] heap_waddr;
    entry_t        heap_wdata;
    logic          is_visit, is_flood;

    assign wc = CW'(w_reg);
    assign dc = CW'(d_reg);

    assign grid_ok      = (w_reg >= 13'd2) && (d_reg >= 13'd2) && (area_reg <= MAX_CELLS);
    assign in_range_in  = grid_ok && ({14'd0, cell_index} < area_reg);
    assign in_range_idx = grid_ok && ({14'd0, idx_reg} < area_reg);

    assign area_next = (wr_index == REG_GRID_WIDTH) ? 26'(wr_data) * 26'(d_reg)
                                                    : 26'(w_reg) * 26'(wr_data);

    assign mul_a    = (ctl.op == OP_RUN_INIT) ? dc - CW'(1) : top_reg.z;
    assign mul_prod = (CW+13)'(mul_a) * (CW+13)'(w_reg);

    // border seed generator
    always_comb
    begin
        if (gphase_reg)
        begin
            seed_cell = gside_reg ? row_base_reg + wc - CW'(1) : row_base_reg;
            seed_x    = gside_reg ? wc - CW'(1) : '0;
            seed_z    = gcnt_reg;
        end
        else
        begin
            seed_cell = gside_reg ? last_base_reg + gcnt_reg : gcnt_reg;
            seed_x    = gcnt_reg;
            seed_z    = gside_reg ? dc - CW'(1) : '0;
        end
    end

    // neighbor generator, offsets held as 0..2
    assign nx1       = {1'b0, top_reg.x} + (CW+1)'(dxi_reg);
    assign nz1       = {1'b0, top_reg.z} + (CW+1)'(dzi_reg);
    assign nbr_valid = (nx1 != '0) && (nx1 <= w_reg) && (nz1 != '0) && (nz1 <= d_reg)
                       && !((dxi_reg == 2'd1) && (dzi_reg == 2'd1));
    assign nbr_last  = (dxi_reg == 2'd2) && (dzi_reg == 2'd2);

    always_comb
    begin
        case (dzi_reg)
            2'd0:    nbr_base = pcell_reg - wc;
            2'd2:    nbr_base = pcell_reg + wc;
            default: nbr_base = pcell_reg;
        endcase
    end

    assign nbr_cell = nbr_base + CW'(dxi_reg) - CW'(1);
    assign gen_addr = (ctl.op == OP_NBR_GEN) ? nbr_cell : seed_cell;

    assign dist_raddr = (ctl.op == OP_PDIST) ? pcell_reg : CW'(cell_index);

    // heap sift-down helpers
    assign sift_l    = {1'b0, hi_reg, 1'b1};
    assign sift_leaf = sift_l >= {1'b0, heap_cnt_reg};
    assign sel_r     = has_r_reg && less(heap_rd, lch_reg);
    assign child     = sel_r ? heap_rd : lch_reg;
    assign midx      = sel_r ? lidx_reg + (CW+2)'(1) : lidx_reg;
    assign sift_down = less(child, last_reg);

    always_comb
    begin
        case (ctl.op)
            OP_PUSH_RD: heap_raddr = CW'((hi_reg - CW'(1)) >> 1);
            OP_POP_TOP: heap_raddr = CW'(heap_cnt_reg - (CW+1)'(1));
            OP_SIFT_L:  heap_raddr = CW'(sift_l);
            OP_SIFT_R:  heap_raddr = CW'(lidx_reg + (CW+2)'(1));
            default:    heap_raddr = '0;
        endcase
    end

    always_comb
    begin
        heap_we    = 1'b0;
        heap_waddr = hi_reg;
        heap_wdata = e_reg;
        case (ctl.op)
            OP_PUSH_RD:  heap_we = (hi_reg == '0);
            OP_PUSH_CMP:
            begin
                heap_we    = 1'b1;
                heap_wdata = less(e_reg, heap_rd) ? heap_rd : e_reg;
            end
            OP_SIFT_L:
            begin
                heap_we    = sift_leaf && (heap_cnt_reg != '0);
                heap_wdata = last_reg;
            end
            OP_SIFT_CMP:
            begin
                heap_we    = 1'b1;
                heap_wdata = sift_down ? child : last_reg;
            end
            default: heap_we = 1'b0;
        endcase
    end

    // visit of a candidate cell
    assign is_flood   = (ctl.op == OP_VISIT_FLOOD);
    assign is_visit   = (ctl.op == OP_VISIT_SEED) || is_flood;
    assign flood_elev = (height_rd > top_reg.elev) ? height_rd : top_reg.elev;
    assign visit_elev = is_flood ? flood_elev : height_rd;
    assign store_we   = is_visit && !visited_rd;
    assign visit_we   = store_we || (ctl.op == OP_CLEAR);
    assign visit_wd   = (ctl.op != OP_CLEAR);
    assign visit_addr = (ctl.op == OP_CLEAR) ? gcnt_reg : cur_cell_reg;

    // memory ports
    always_ff @(posedge clk)
    begin
        if ((ctl.op == OP_WRITE) && in_range_in)
            height_mem[CW'(cell_index)] <= HB'(height);
        height_rd <= height_mem[gen_addr];
    end

    always_ff @(posedge clk)
    begin
        if (visit_we)
            visited_mem[visit_addr] <= visit_wd;
        visited_rd <= visited_mem[gen_addr];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            filled_mem[cur_cell_reg] <= visit_elev;
        filled_rd <= filled_mem[CW'(cell_index)];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            drain_mem[cur_cell_reg] <= is_flood ? {1'b1, pcell_reg} : '0;
        drain_rd <= drain_mem[CW'(cell_index)];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            dist_mem[cur_cell_reg] <= is_flood ? pdist_reg + CW'(1) : '0;
        dist_rd <= dist_mem[dist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_waddr] <= heap_wdata;
        heap_rd <= heap_mem[heap_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= 13'd64;
            d_reg        <= 13'd64;
            area_reg     <= 26'd4096;
            ready_reg    <= 1'b0;
            heap_cnt_reg <= '0;
            seq_reg      <= '0;
            gen_done_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.op inside {OP_WRITE, OP_READ_OUT, OP_REJECT, OP_RUN_BAD,
                                       OP_FINISH};
            if (wr_en)
            begin
                if (wr_index == REG_GRID_WIDTH)
                    w_reg <= wr_data;
                else
                    d_reg <= wr_data;
                area_reg <= area_next;
            end
            if (wr_en || (ctl.op == OP_RUN_BAD) || ((ctl.op == OP_WRITE) && in_range_in))
                ready_reg <= 1'b0;
            else if (ctl.op == OP_FINISH)
                ready_reg <= 1'b1;
            case (ctl.op)
                OP_RUN_INIT:
                begin
                    heap_cnt_reg <= '0;
                    seq_reg      <= '0;
                end
                OP_CLEAR: gen_done_reg <= 1'b0;
                OP_SEED_GEN:
                begin
                    if (gphase_reg && gside_reg && (gcnt_reg == dc - CW'(1)))
                        gen_done_reg <= 1'b1;
                end
                OP_VISIT_SEED, OP_VISIT_FLOOD:
                begin
                    if (!visited_rd)
                    begin
                        heap_cnt_reg <= heap_cnt_reg + (CW+1)'(1);
                        seq_reg      <= seq_reg + CW'(1);
                    end
                end
                OP_POP_TOP: heap_cnt_reg <= heap_cnt_reg - (CW+1)'(1);
                OP_PDIST:   gen_done_reg <= 1'b0;
                OP_NBR_GEN:
                begin
                    if (nbr_last)
                        gen_done_reg <= 1'b1;
                end
                default: heap_cnt_reg <= heap_cnt_reg;
            endcase
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_WRITE:
            begin
                status_reg <= in_range_in ? ST_OK : ST_RANGE;
                fh_reg     <= '0;
                hd_reg     <= 1'b0;
                dc_reg     <= '0;
                ed_reg     <= '0;
            end
            OP_READ_ISSUE: idx_reg <= cell_index;
            OP_READ_OUT:
            begin
                fh_reg <= '0;
                hd_reg <= 1'b0;
                dc_reg <= '0;
                ed_reg <= '0;
                if (!in_range_idx)
                    status_reg <= ST_RANGE;
                else if (!ready_reg)
                    status_reg <= ST_NOFILL;
                else
                begin
                    status_reg <= ST_OK;
                    fh_reg     <= 16'(filled_rd);
                    hd_reg     <= drain_rd[CW];
                    dc_reg     <= drain_rd[CW] ? 12'(drain_rd[CW-1:0]) : '0;
                    ed_reg     <= 12'(dist_rd);
                end
            end
            OP_REJECT, OP_RUN_BAD:
            begin
                status_reg <= ST_RANGE;
                fh_reg     <= '0;
                hd_reg     <= 1'b0;
                dc_reg     <= '0;
                ed_reg     <= '0;
            end
            OP_FINISH:
            begin
                status_reg <= ST_OK;
                fh_reg     <= '0;
                hd_reg     <= 1'b0;
                dc_reg     <= '0;
                ed_reg     <= '0;
            end
            OP_RUN_INIT:
            begin
                last_base_reg <= CW'(mul_prod);
                gcnt_reg      <= '0;
            end
            OP_CLEAR:
            begin
                gphase_reg   <= 1'b0;
                gside_reg    <= 1'b0;
                row_base_reg <= '0;
                if (st.clear_last)
                    gcnt_reg <= '0;
                else
                    gcnt_reg <= gcnt_reg + CW'(1);
            end
            OP_SEED_GEN:
            begin
                cur_cell_reg <= seed_cell;
                cur_x_reg    <= seed_x;
                cur_z_reg    <= seed_z;
                gside_reg    <= !gside_reg;
                if (gside_reg)
                begin
                    if (!gphase_reg)
                    begin
                        if (gcnt_reg == wc - CW'(1))
                        begin
                            gphase_reg <= 1'b1;
                            gcnt_reg   <= '0;
                        end
                        else
                            gcnt_reg <= gcnt_reg + CW'(1);
                    end
                    else
                    begin
                        gcnt_reg     <= gcnt_reg + CW'(1);
                        row_base_reg <= row_base_reg + wc;
                    end
                end
            end
            OP_VISIT_SEED, OP_VISIT_FLOOD:
            begin
                e_reg.elev <= visit_elev;
                e_reg.seq  <= seq_reg;
                e_reg.x    <= cur_x_reg;
                e_reg.z    <= cur_z_reg;
                hi_reg     <= CW'(heap_cnt_reg);
            end
            OP_PUSH_RD: pidx_reg <= CW'((hi_reg - CW'(1)) >> 1);
            OP_PUSH_CMP:
            begin
                if (less(e_reg, heap_rd))
                    hi_reg <= pidx_reg;
            end
            OP_POP_TOP:  top_reg <= heap_rd;
            OP_POP_LAST:
            begin
                last_reg <= heap_rd;
                hi_reg   <= '0;
            end
            OP_SIFT_L: lidx_reg <= sift_l;
            OP_SIFT_R:
            begin
                lch_reg   <= heap_rd;
                has_r_reg <= (lidx_reg + (CW+2)'(1)) < {1'b0, heap_cnt_reg};
            end
            OP_SIFT_CMP:
            begin
                if (sift_down)
                    hi_reg <= CW'(midx);
            end
            OP_PCELL: pcell_reg <= CW'(mul_prod) + top_reg.x;
            OP_PDIST:
            begin
                dxi_reg <= '0;
                dzi_reg <= '0;
            end
            OP_PDIST_CAP: pdist_reg <= dist_rd;
            OP_NBR_GEN:
            begin
                cur_cell_reg <= nbr_cell;
                cur_x_reg    <= CW'(nx1 - (CW+1)'(1));
                cur_z_reg    <= CW'(nz1 - (CW+1)'(1));
                if (dxi_reg == 2'd2)
                begin
                    dxi_reg <= '0;
                    dzi_reg <= dzi_reg + 2'd1;
                end
                else
                    dxi_reg <= dxi_reg + 2'd1;
            end
            default: pdist_reg <= pdist_reg;
        endcase
    end

    assign st.grid_ok    = grid_ok;
    assign st.clear_last = ((26'(gcnt_reg) + 26'd1) == area_reg);
    assign st.gen_done   = gen_done_reg;
    assign st.fresh      = !visited_rd;
    assign st.push_top   = (hi_reg == '0);
    assign st.push_up    = less(e_reg, heap_rd);
    assign st.heap_empty = (heap_cnt_reg == '0);
    assign st.sift_leaf  = sift_leaf;
    assign st.sift_down  = sift_down;
    assign st.nbr_valid  = nbr_valid;
    assign st.nbr_last   = nbr_last;

    assign done            = done_reg;
    assign status          = status_reg;
    assign filled_height   = fh_reg;
    assign has_downstream  = hd_reg;
    assign downstream_cell = dc_reg;
    assign edge_distance   = ed_reg;

endmodule

// ===== rtl/priority_flood_fill.sv =====
// ----------------------------------------------------------------------------
// priority_flood_fill: priority-flood depression filling of an elevation grid
// Write heights, run the fill, read filled height, drain cell and distance.
// ----------------------------------------------------------------------------
// results: writes and rejected commands report in the next cycle after acceptance with
//   busy low; reads register the index, then report with busy high for one cycle
// run: clears the visited flag of every grid cell, pushes the border seeds, then pops
//   the lowest entry, sifts the heap down and visits each neighbor, pushing fresh cells
//   with a sift-up, until the heap is empty
// reset clears control state and sets the grid to 64 by 64; done cannot be stalled
module priority_flood_fill #(
    parameter int MAX_CELLS   = 4096,
    parameter int HEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [11:0] cell_index,
    input  logic [15:0] height,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [12:0] wr_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] filled_height,
    output logic        has_downstream,
    output logic [11:0] downstream_cell,
    output logic [11:0] edge_distance
);
    import pff_pkg::*;

    dp_ctl_t    ctl;
    dp_status_t st;

    pff_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .st    (st),
        .ctl   (ctl),
        .busy  (busy)
    );

    pff_datapath #(
        .MAX_CELLS   (MAX_CELLS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .st              (st),
        .cell_index      (cell_index),
        .height          (height),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .done            (done),
        .status          (status),
        .filled_height   (filled_height),
        .has_downstream  (has_downstream),
        .downstream_cell (downstream_cell),
        .edge_distance   (edge_distance)
    );

endmodule

// ===== rtl/pff_checker.sv =====
// ----------------------------------------------------------------------------
// pff_checker: port-level checks for the priority flood fill
// Command/result sequencing and result field consistency.
// ----------------------------------------------------------------------------
module pff_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [15:0] filled_height,
    input logic        has_downstream,
    input logic [11:0] downstream_cell,
    input logic [11:0] edge_distance
);
    import pff_pkg::*;

    // an accepted transfer either reports next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("accepted command neither reported nor busy");

    // leaving busy always comes with a result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK) || (status == ST_RANGE) || (status == ST_NOFILL))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (filled_height == 16'd0) && !has_downstream
            && (downstream_cell == 12'd0) && (edge_distance == 12'd0))
        else $error("failed command carries nonzero fields");

    a_no_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done && !has_downstream |-> (downstream_cell == 12'd0))
        else $error("drain cell without downstream flag");

endmodule

bind priority_flood_fill pff_checker u_pff_checker (.*);
